>>> design/edf_pkg.sv
`timescale 1ns / 1ps

package edf_pkg;

    localparam int DEPTH_DEF = 64;

    localparam logic [2:0] OP_CREATE   = 3'd0;
    localparam logic [2:0] OP_FREE     = 3'd1;
    localparam logic [2:0] OP_EXEC     = 3'd2;
    localparam logic [2:0] OP_DEADLINE = 3'd3;
    localparam logic [2:0] OP_RATE     = 3'd4;
    localparam logic [2:0] OP_POLICY   = 3'd5;

    localparam logic [1:0] POL_EDF  = 2'd0;
    localparam logic [1:0] POL_RMS  = 2'd1;
    localparam logic [1:0] POL_NONE = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_NOSCHED  = 2'd2;
    localparam logic [1:0] ST_ZERO     = 2'd3;

    localparam int DIV_BITS  = 40;
    localparam int DIV_RADIX = 4;
    localparam int DIV_CYC   = DIV_BITS / DIV_RADIX;
    localparam int SUM_W     = 47;

    localparam logic [13:0] LL_BOUND [64] = '{
        14'd10000, 14'd8284, 14'd7798, 14'd7568, 14'd7435, 14'd7348, 14'd7286, 14'd7241,
        14'd7205, 14'd7177, 14'd7155, 14'd7136, 14'd7120, 14'd7106, 14'd7094, 14'd7084,
        14'd7075, 14'd7067, 14'd7059, 14'd7053, 14'd7047, 14'd7042, 14'd7037, 14'd7033,
        14'd7028, 14'd7025, 14'd7021, 14'd7018, 14'd7015, 14'd7012, 14'd7010, 14'd7007,
        14'd7005, 14'd7003, 14'd7001, 14'd6999, 14'd6997, 14'd6995, 14'd6993, 14'd6992,
        14'd6990, 14'd6989, 14'd6988, 14'd6986, 14'd6985, 14'd6984, 14'd6983, 14'd6982,
        14'd6981, 14'd6980, 14'd6979, 14'd6978, 14'd6977, 14'd6976, 14'd6975, 14'd6975,
        14'd6974, 14'd6973, 14'd6972, 14'd6972, 14'd6971, 14'd6970, 14'd6970, 14'd6969
    };

    // sum*100 > bound holds exactly when sum > floor(bound/100)
    function automatic logic [6:0] ll_limit(input logic [5:0] idx);
        return 7'(LL_BOUND[idx] / 100);
    endfunction

    typedef struct packed {
        logic [2:0]  operation;
        logic [15:0] task_id;
        logic [15:0] value;
        logic [31:0] now_tick;
    } t_in;

    typedef struct packed {
        logic [1:0] status;
        logic [2:0] priority_res;
        logic [7:0] edf_total;
        logic [7:0] rms_total;
    } t_out;

    typedef struct packed {
        logic [15:0] task_id;
        logic [15:0] exec;
        logic [15:0] deadline;
        logic [15:0] rate;
        logic [1:0]  policy;
    } t_entry;

    typedef struct packed {
        logic load;
        logic rd;
        logic eval;
        logic div_step;
        logic acc;
        logic next;
        logic wb;
    } t_cmd;

    typedef struct packed {
        logic div_need;
        logic mul_need;
        logic div_done;
        logic last;
    } t_sts;

endpackage

>>> design/edf_rms_admission_table_core.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake                 Payload
// command   in         start && !busy            i_in  (edf_pkg::t_in)
// result    out        o_valid, one cycle        o_out (edf_pkg::t_out)
//
// Every command scans all TABLE_DEPTH slots through the entry RAM; each slot is
// read and evaluated, an RMS term or a nonzero-deadline EDF term (radix-16 divider)
// is accumulated, then a write-back; the result strobe follows in the next cycle.
// Synchronous active-low reset clears slot flags and counters; no
// clearing pass. The receiver cannot stall: o_valid lasts exactly one cycle.

module edf_rms_admission_table_core #(
    parameter int TABLE_DEPTH = edf_pkg::DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  edf_pkg::t_in  i_in,
    output logic          busy,
    output logic          o_valid,
    output edf_pkg::t_out o_out
);

    edf_pkg::t_cmd cmd;
    edf_pkg::t_sts sts;

    edf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    edf_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_in    (i_in),
        .o_sts   (sts),
        .o_valid (o_valid),
        .o_out   (o_out)
    );

endmodule

>>> design/edf_ram.sv
`timescale 1ns / 1ps

module edf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/edf_ctrl.sv
`timescale 1ns / 1ps

module edf_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  edf_pkg::t_sts i_sts,
    output edf_pkg::t_cmd o_cmd,
    output logic          o_busy
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_READ = 6'b000010,
        S_EVAL = 6'b000100,
        S_DIV  = 6'b001000,
        S_ACC  = 6'b010000,
        S_WB   = 6'b100000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_EVAL;
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                if (i_sts.div_need) begin
                    n_state = S_DIV;
                end else if (i_sts.mul_need) begin
                    n_state = S_ACC;
                end else if (i_sts.last) begin
                    n_state = S_WB;
                end else begin
                    o_cmd.next = 1'b1;
                    n_state    = S_READ;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_done) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                if (i_sts.last) begin
                    n_state = S_WB;
                end else begin
                    o_cmd.next = 1'b1;
                    n_state    = S_READ;
                end
            end
            S_WB: begin
                o_cmd.wb = 1'b1;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

>>> design/edf_dp.sv
`timescale 1ns / 1ps

module edf_dp #(
    parameter int TABLE_DEPTH = edf_pkg::DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  edf_pkg::t_cmd i_cmd,
    input  edf_pkg::t_in  i_in,
    output edf_pkg::t_sts o_sts,
    output logic          o_valid,
    output edf_pkg::t_out o_out
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int DCW = $clog2(edf_pkg::DIV_CYC);

    edf_pkg::t_in    r_req;
    logic [AW-1:0]   r_idx;
    logic            r_found, r_free_ok, r_zero;
    logic [AW-1:0]   r_hit, r_free;
    edf_pkg::t_entry r_hit_ent;
    logic [CW-1:0]   r_cnt;
    logic [31:0]     r_prod;
    logic [edf_pkg::SUM_W-1:0] r_sum;
    logic [15:0]     r_rem;
    logic [edf_pkg::DIV_BITS-1:0] r_quo;
    logic [DCW-1:0]  r_dcnt;
    logic            r_used [TABLE_DEPTH];
    logic [7:0]      r_edf, r_rms;
    logic            r_valid;
    edf_pkg::t_out   r_out;

    edf_pkg::t_entry rd_ent, wr_ent;
    logic            we;
    logic [AW-1:0]   waddr;
    logic [1:0]      req_pol;
    logic            is_pol, match, contrib, edf_c, rms_c;
    logic [15:0]     n_rem;
    logic [edf_pkg::DIV_BITS-1:0] n_quo;
    logic [16:0]     t_rem;
    logic [1:0]      status;
    logic [2:0]      prio;
    logic [5:0]      ll_idx;
    logic [6:0]      x3;

    edf_ram #(.WIDTH($bits(edf_pkg::t_entry)), .DEPTH(TABLE_DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wr_ent),
        .i_re    (i_cmd.rd),
        .i_raddr (r_idx),
        .o_rdata (rd_ent)
    );

    assign req_pol = (r_req.value == 16'd0) ? edf_pkg::POL_EDF :
                     (r_req.value == 16'd1) ? edf_pkg::POL_RMS : edf_pkg::POL_NONE;
    assign is_pol  = (r_req.operation == edf_pkg::OP_POLICY);
    assign match   = r_used[r_idx] && (rd_ent.task_id == r_req.task_id);
    assign contrib = r_used[r_idx] && ((rd_ent.policy == req_pol) || match);
    assign edf_c   = is_pol && (req_pol == edf_pkg::POL_EDF) && contrib;
    assign rms_c   = is_pol && (req_pol == edf_pkg::POL_RMS) && contrib;

    assign o_sts.div_need = edf_c && (rd_ent.deadline != 16'd0);
    assign o_sts.mul_need = rms_c;
    assign o_sts.div_done = (r_dcnt == DCW'(edf_pkg::DIV_CYC - 1));
    assign o_sts.last     = (r_idx == AW'(TABLE_DEPTH - 1));

    always_comb begin
        n_rem = r_rem;
        n_quo = r_quo;
        t_rem = '0;
        for (int k = 0; k < edf_pkg::DIV_RADIX; k++) begin
            t_rem = {n_rem, n_quo[edf_pkg::DIV_BITS-1]};
            n_quo = {n_quo[edf_pkg::DIV_BITS-2:0], 1'b0};
            if (t_rem >= {1'b0, rd_ent.deadline}) begin
                n_rem    = 16'(t_rem - {1'b0, rd_ent.deadline});
                n_quo[0] = 1'b1;
            end else begin
                n_rem = t_rem[15:0];
            end
        end
    end

    always_comb begin
        x3 = 7'd0;
        if (r_req.value <= 16'd30) begin
            x3 = 7'(5'(16'd30 - r_req.value) * 3);
            prio = (x3 >= 7'd87) ? 3'd4 : (x3 >= 7'd58) ? 3'd3 :
                   (x3 >= 7'd29) ? 3'd2 : 3'd1;
        end else begin
            prio = 3'd1;
        end
    end

    assign ll_idx = (r_cnt == '0) ? 6'd0 : 6'(r_cnt - CW'(1));

    always_comb begin
        status = edf_pkg::ST_OK;
        if (r_req.operation == edf_pkg::OP_CREATE) begin
            if (!r_free_ok) begin
                status = edf_pkg::ST_NOTFOUND;
            end
        end else if (r_req.operation >= edf_pkg::OP_FREE &&
                     r_req.operation <= edf_pkg::OP_POLICY) begin
            if (!r_found) begin
                status = edf_pkg::ST_NOTFOUND;
            end else if (is_pol && req_pol == edf_pkg::POL_EDF) begin
                if (r_zero) begin
                    status = edf_pkg::ST_ZERO;
                end else if (r_sum > edf_pkg::SUM_W'(1 << 24)) begin
                    status = edf_pkg::ST_NOSCHED;
                end
            end else if (is_pol && req_pol == edf_pkg::POL_RMS) begin
                if (r_sum > edf_pkg::SUM_W'(edf_pkg::ll_limit(ll_idx))) begin
                    status = edf_pkg::ST_NOSCHED;
                end
            end
        end
    end

    always_comb begin
        we     = 1'b0;
        waddr  = r_hit;
        wr_ent = r_hit_ent;
        if (i_cmd.wb) begin
            unique case (r_req.operation)
                edf_pkg::OP_CREATE: begin
                    we     = r_free_ok;
                    waddr  = r_free;
                    wr_ent = '{task_id: r_req.task_id, exec: 16'd0, deadline: 16'd0,
                               rate: 16'd0, policy: edf_pkg::POL_NONE};
                end
                edf_pkg::OP_EXEC: begin
                    we          = r_found;
                    wr_ent.exec = r_req.value;
                end
                edf_pkg::OP_DEADLINE: begin
                    we              = r_found;
                    wr_ent.deadline = r_req.value;
                end
                edf_pkg::OP_RATE: begin
                    we          = r_found;
                    wr_ent.rate = r_req.value;
                end
                edf_pkg::OP_POLICY: begin
                    we            = r_found && (status == edf_pkg::ST_OK);
                    wr_ent.policy = req_pol;
                end
                default: begin
                    we = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req     <= i_in;
            r_idx     <= '0;
            r_found   <= 1'b0;
            r_free_ok <= 1'b0;
            r_zero    <= 1'b0;
            r_cnt     <= '0;
            r_sum     <= '0;
        end
        if (i_cmd.next) begin
            r_idx <= r_idx + AW'(1);
        end
        if (i_cmd.eval) begin
            if (!r_found && match) begin
                r_found   <= 1'b1;
                r_hit     <= r_idx;
                r_hit_ent <= rd_ent;
            end
            if (!r_free_ok && !r_used[r_idx]) begin
                r_free_ok <= 1'b1;
                r_free    <= r_idx;
            end
            if (edf_c && rd_ent.deadline == 16'd0) begin
                r_zero <= 1'b1;
            end
            if (rms_c) begin
                r_cnt <= r_cnt + CW'(1);
            end
            r_prod <= rd_ent.exec * rd_ent.rate;
            r_quo  <= {rd_ent.exec, 24'd0};
            r_rem  <= '0;
            r_dcnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_quo  <= n_quo;
            r_rem  <= n_rem;
            r_dcnt <= r_dcnt + DCW'(1);
        end
        if (i_cmd.acc) begin
            if (req_pol == edf_pkg::POL_EDF) begin
                r_sum <= r_sum + edf_pkg::SUM_W'(r_quo);
            end else begin
                r_sum <= r_sum + edf_pkg::SUM_W'(r_prod);
            end
        end
        if (i_cmd.wb) begin
            r_out.status       <= status;
            r_out.priority_res <= (r_req.operation == edf_pkg::OP_RATE && r_found) ?
                                  prio : 3'd0;
            r_out.edf_total    <= r_edf + 8'((is_pol && r_found && status == edf_pkg::ST_OK
                                  && req_pol == edf_pkg::POL_EDF) ? 1 : 0);
            r_out.rms_total    <= r_rms + 8'((is_pol && r_found && status == edf_pkg::ST_OK
                                  && req_pol == edf_pkg::POL_RMS) ? 1 : 0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_edf   <= '0;
            r_rms   <= '0;
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                r_used[i] <= 1'b0;
            end
        end else begin
            r_valid <= i_cmd.wb;
            if (i_cmd.wb) begin
                if (r_req.operation == edf_pkg::OP_CREATE && r_free_ok) begin
                    r_used[r_free] <= 1'b1;
                end
                if (r_req.operation == edf_pkg::OP_FREE && r_found) begin
                    r_used[r_hit] <= 1'b0;
                end
                if (is_pol && r_found && status == edf_pkg::ST_OK) begin
                    if (req_pol == edf_pkg::POL_EDF) begin
                        r_edf <= r_edf + 8'd1;
                    end
                    if (req_pol == edf_pkg::POL_RMS) begin
                        r_rms <= r_rms + 8'd1;
                    end
                end
            end
        end
    end

    assign o_valid = r_valid;
    assign o_out   = r_out;

    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |=> !r_valid) else $error("result strobe longer than one cycle");

    a_zero_policy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_out.status == edf_pkg::ST_ZERO) |-> is_pol)
        else $error("zero deadline reported outside a policy request");

    a_cnt_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_edf != $past(r_edf) || r_rms != $past(r_rms)) |-> r_valid)
        else $error("policy counter moved without a result");

    a_div_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (rd_ent.deadline != 16'd0))
        else $error("divide by zero deadline");

endmodule

>>> tb/edf_rms_admission_table_core_test.sv
`timescale 1ns / 1ps

module edf_rms_admission_table_core_test;

    localparam int SLOTS    = 64;
    localparam int WDOG_MAX = 20000;

    typedef struct {
        edf_pkg::t_in cmd;
        bit           fixed;
        logic [1:0]   st;
        logic [2:0]   pr;
    } t_row;

    logic          i_clk   = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          start   = 1'b0;
    edf_pkg::t_in  i_in    = '0;
    logic          busy;
    logic          o_valid;
    edf_pkg::t_out o_out;

    edf_rms_admission_table_core dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .i_in   (i_in),
        .busy   (busy),
        .o_valid(o_valid),
        .o_out  (o_out)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    bit          m_used   [SLOTS];
    bit          m_zombie [SLOTS];
    logic [15:0] m_id     [SLOTS];
    logic [1:0]  m_pol    [SLOTS];
    logic [15:0] m_exec   [SLOTS];
    logic [15:0] m_dl     [SLOTS];
    logic [15:0] m_rate   [SLOTS];
    logic [2:0]  m_prio   [SLOTS];
    logic [31:0] m_arr    [SLOTS];
    logic [7:0]  m_edf_cnt;
    logic [7:0]  m_rms_cnt;

    edf_pkg::t_out pending_results[$];
    int          errors = 0;
    int          wdog   = 0;
    bit          cur_fixed;
    logic [1:0]  cur_st;
    logic [2:0]  cur_pr;
    t_row        rows[$];

    function automatic void clear_slot(int i);
        m_used[i]   = 1'b0;
        m_zombie[i] = 1'b0;
        m_id[i]     = '0;
        m_pol[i]    = edf_pkg::POL_NONE;
        m_exec[i]   = '0;
        m_dl[i]     = '0;
        m_rate[i]   = '0;
        m_prio[i]   = '0;
        m_arr[i]    = '0;
    endfunction

    function automatic logic [1:0] edf_admit(logic [15:0] id);
        longint unsigned sum;
        sum = 0;
        for (int i = 0; i < SLOTS; i++) begin
            if (m_used[i] && (m_pol[i] == edf_pkg::POL_EDF || m_id[i] == id)) begin
                if (m_dl[i] == 0)
                    return edf_pkg::ST_ZERO;
                sum += ({48'd0, m_exec[i]} << 24) / m_dl[i];
            end
        end
        return (sum > 64'd16777216) ? edf_pkg::ST_NOSCHED : edf_pkg::ST_OK;
    endfunction

    function automatic logic [1:0] rms_admit(logic [15:0] id);
        longint unsigned sum;
        int n;
        sum = 0;
        n = 0;
        for (int i = 0; i < SLOTS; i++) begin
            if (m_used[i] && (m_pol[i] == edf_pkg::POL_RMS || m_id[i] == id)) begin
                n++;
                sum += longint'(m_exec[i]) * longint'(m_rate[i]);
            end
        end
        if (n == 0)
            n = 1;
        return (sum * 100 > edf_pkg::LL_BOUND[n - 1]) ? edf_pkg::ST_NOSCHED : edf_pkg::ST_OK;
    endfunction

    function automatic edf_pkg::t_out admit_step(edf_pkg::t_in c);
        edf_pkg::t_out r;
        int s;
        int f;
        logic [1:0] pol;
        r = '0;
        s = -1;
        f = -1;
        if (c.operation >= edf_pkg::OP_FREE && c.operation <= edf_pkg::OP_POLICY) begin
            for (int i = SLOTS - 1; i >= 0; i--)
                if (m_used[i] && m_id[i] == c.task_id)
                    s = i;
            if (s < 0)
                r.status = edf_pkg::ST_NOTFOUND;
        end
        if (c.operation == edf_pkg::OP_CREATE) begin
            for (int i = SLOTS - 1; i >= 0; i--)
                if (!m_used[i])
                    f = i;
            if (f >= 0) begin
                clear_slot(f);
                m_used[f] = 1'b1;
                m_id[f]   = c.task_id;
            end else begin
                r.status = edf_pkg::ST_NOTFOUND;
            end
        end else if (s >= 0) begin
            case (c.operation)
                edf_pkg::OP_FREE: clear_slot(s);
                edf_pkg::OP_EXEC: m_exec[s] = c.value;
                edf_pkg::OP_DEADLINE: m_dl[s] = c.value;
                edf_pkg::OP_RATE: begin
                    m_rate[s] = c.value;
                    r.priority_res = (c.value <= 30) ? 3'((30 - c.value) * 3 / 29 + 1) : 3'd1;
                    m_prio[s] = r.priority_res;
                end
                default: begin
                    pol = (c.value == 0) ? edf_pkg::POL_EDF :
                          (c.value == 1) ? edf_pkg::POL_RMS : edf_pkg::POL_NONE;
                    if (pol == edf_pkg::POL_EDF)
                        r.status = edf_admit(c.task_id);
                    else if (pol == edf_pkg::POL_RMS)
                        r.status = rms_admit(c.task_id);
                    if (r.status == edf_pkg::ST_NOSCHED) begin
                        m_zombie[s] = 1'b1;
                    end else if (r.status == edf_pkg::ST_OK) begin
                        m_arr[s] = c.now_tick;
                        m_pol[s] = pol;
                        if (pol == edf_pkg::POL_EDF)
                            m_edf_cnt++;
                        else if (pol == edf_pkg::POL_RMS)
                            m_rms_cnt++;
                    end
                end
            endcase
        end
        r.edf_total = m_edf_cnt;
        r.rms_total = m_rms_cnt;
        return r;
    endfunction

    always @(posedge i_clk) begin
        edf_pkg::t_out want;
        edf_pkg::t_out got;
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++)
                clear_slot(i);
            m_edf_cnt = '0;
            m_rms_cnt = '0;
        end else begin
            got = o_out;
            if (o_valid) begin
                if (pending_results.size() == 0) begin
                    $error("unexpected result transaction %p", got);
                    errors++;
                end else begin
                    want = pending_results.pop_front();
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        errors++;
                    end
                    if (got.priority_res !== want.priority_res) begin
                        $error("priority_res: expected %0d, got %0d",
                               want.priority_res, got.priority_res);
                        errors++;
                    end
                    if (got.edf_total !== want.edf_total) begin
                        $error("edf_total: expected %0d, got %0d", want.edf_total, got.edf_total);
                        errors++;
                    end
                    if (got.rms_total !== want.rms_total) begin
                        $error("rms_total: expected %0d, got %0d", want.rms_total, got.rms_total);
                        errors++;
                    end
                end
            end
            if (start && !busy) begin
                want = admit_step(i_in);
                if (cur_fixed) begin
                    want.status       = cur_st;
                    want.priority_res = cur_pr;
                end
                pending_results.push_back(want);
            end
            if (o_valid || (start && !busy))
                wdog = 0;
            else
                wdog++;
            if (wdog >= WDOG_MAX) begin
                $display("edf_rms_admission_table_core_test failed");
                $finish;
            end
        end
    end

    task automatic send(edf_pkg::t_in c, bit fixed, logic [1:0] st, logic [2:0] pr,
                        int idle_pct);
        int gap;
        gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 8) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cur_fixed <= fixed;
        cur_st    <= st;
        cur_pr    <= pr;
        start     <= 1'b1;
        i_in      <= c;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic add_row(logic [2:0] op, logic [15:0] id, logic [15:0] val,
                           bit fixed, logic [1:0] st, logic [2:0] pr);
        t_row r;
        r.cmd   = '{operation: op, task_id: id, value: val, now_tick: $urandom};
        r.fixed = fixed;
        r.st    = st;
        r.pr    = pr;
        rows.push_back(r);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick(int lo, int hi);
        case ($urandom_range(0, 9))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'($urandom);
            default: return 16'($urandom_range(lo, hi));
        endcase
    endfunction

    function automatic edf_pkg::t_in rand_cmd(int step, logic [15:0] id);
        edf_pkg::t_in c;
        c.task_id  = id;
        c.now_tick = $urandom;
        case (step)
            0: begin c.operation = edf_pkg::OP_CREATE;   c.value = 16'($urandom); end
            1: begin c.operation = edf_pkg::OP_EXEC;     c.value = pick(1, 12); end
            2: begin c.operation = edf_pkg::OP_DEADLINE; c.value = pick(20, 400); end
            3: begin c.operation = edf_pkg::OP_RATE;     c.value = pick(0, 40); end
            4: begin c.operation = edf_pkg::OP_POLICY;
                c.value = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2));
            end
            5: begin c.operation = edf_pkg::OP_FREE;     c.value = 16'($urandom); end
            default: begin
                c.operation = 3'($urandom_range(0, 7));
                c.value     = 16'($urandom);
            end
        endcase
        return c;
    endfunction

    initial begin
        int idle_pct [3];
        int sent;
        logic [15:0] id;
        idle_pct = '{0, 65, 29};

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        add_row(edf_pkg::OP_FREE,     16'd5,    16'd0,    1, edf_pkg::ST_NOTFOUND, 3'd0);
        add_row(edf_pkg::OP_POLICY,   16'd5,    16'd0,    1, edf_pkg::ST_NOTFOUND, 3'd0);
        add_row(edf_pkg::OP_EXEC,     16'd0,    16'hFFFF, 1, edf_pkg::ST_NOTFOUND, 3'd0);
        add_row(edf_pkg::OP_CREATE,   16'hFFFF, 16'hFFFF, 1, edf_pkg::ST_OK,       3'd0);
        add_row(edf_pkg::OP_CREATE,   16'd0,    16'd0,    1, edf_pkg::ST_OK,       3'd0);
        add_row(edf_pkg::OP_EXEC,     16'd0,    16'hFFFF, 1, edf_pkg::ST_OK,       3'd0);
        add_row(edf_pkg::OP_POLICY,   16'd0,    16'd0,    1, edf_pkg::ST_ZERO,     3'd0);
        add_row(edf_pkg::OP_DEADLINE, 16'd0,    16'hFFFF, 1, edf_pkg::ST_OK,       3'd0);
        add_row(edf_pkg::OP_POLICY,   16'd0,    16'd0,    0, edf_pkg::ST_OK,       3'd0);
        add_row(edf_pkg::OP_RATE,     16'd0,    16'd0,    1, edf_pkg::ST_OK,       3'd4);
        add_row(edf_pkg::OP_RATE,     16'd0,    16'd30,   1, edf_pkg::ST_OK,       3'd1);
        add_row(edf_pkg::OP_RATE,     16'd0,    16'hFFFF, 1, edf_pkg::ST_OK,       3'd1);
        add_row(edf_pkg::OP_POLICY,   16'd0,    16'd1,    1, edf_pkg::ST_NOSCHED,  3'd0);
        add_row(edf_pkg::OP_POLICY,   16'd0,    16'd7,    1, edf_pkg::ST_OK,       3'd0);
        add_row(edf_pkg::OP_CREATE,   16'd0,    16'd0,    1, edf_pkg::ST_OK,       3'd0);
        add_row(edf_pkg::OP_EXEC,     16'd0,    16'd1,    0, edf_pkg::ST_OK,       3'd0);
        add_row(edf_pkg::OP_POLICY,   16'hFFFF, 16'd0,    1, edf_pkg::ST_ZERO,     3'd0);
        add_row(3'd6,                 16'hAAAA, 16'h5555, 1, edf_pkg::ST_OK,       3'd0);
        add_row(3'd7,                 16'h5555, 16'hAAAA, 1, edf_pkg::ST_OK,       3'd0);
        add_row(edf_pkg::OP_FREE,     16'hFFFF, 16'd0,    1, edf_pkg::ST_OK,       3'd0);
        add_row(edf_pkg::OP_FREE,     16'd0,    16'd0,    1, edf_pkg::ST_OK,       3'd0);
        add_row(edf_pkg::OP_FREE,     16'd0,    16'd0,    1, edf_pkg::ST_OK,       3'd0);
        add_row(edf_pkg::OP_FREE,     16'd0,    16'd0,    1, edf_pkg::ST_NOTFOUND, 3'd0);
        foreach (rows[i])
            send(rows[i].cmd, rows[i].fixed, rows[i].st, rows[i].pr, 0);
        drain();

        for (int i = 0; i < SLOTS + 2; i++)
            send(rand_cmd(0, 16'(16'h100 + i)), 0, edf_pkg::ST_OK, 3'd0, 0);
        for (int i = 0; i < SLOTS + 2; i++)
            send(rand_cmd(5, 16'(16'h100 + i)), 0, edf_pkg::ST_OK, 3'd0, 0);
        drain();

        for (int ph = 0; ph < 3; ph++) begin
            sent = 0;
            while (sent < 130) begin
                id = ($urandom_range(0, 19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 11));
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5, 6: begin
                        for (int k = ($urandom_range(0, 1) ? 0 : 1); k < 5; k++) begin
                            send(rand_cmd(k, id), 0, edf_pkg::ST_OK, 3'd0, idle_pct[ph]);
                            sent++;
                        end
                    end
                    7, 8: begin
                        send(rand_cmd(5, id), 0, edf_pkg::ST_OK, 3'd0, idle_pct[ph]);
                        sent++;
                    end
                    default: begin
                        send(rand_cmd(6, id), 0, edf_pkg::ST_OK, 3'd0, idle_pct[ph]);
                        sent++;
                    end
                endcase
            end
            drain();
        end

        repeat (1000) @(posedge i_clk);
        if (errors == 0 && pending_results.size() == 0)
            $display("edf_rms_admission_table_core_test passed");
        else
            $display("edf_rms_admission_table_core_test failed");
        $finish;
    end

endmodule

>>> sim.f
design/edf_pkg.sv
design/edf_ram.sv
design/edf_ctrl.sv
design/edf_dp.sv
design/edf_rms_admission_table_core.sv
tb/edf_rms_admission_table_core_test.sv
